// File: hdl/ccs_pkg.sv
// ----------------------------------------------------------------------------
// ccs_pkg
// Shared types, constants and the corner-cut arithmetic of the smoother.
// ----------------------------------------------------------------------------
`default_nettype none

package ccs_pkg;

  localparam int unsigned ITER_MAX_DEF    = 5;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;
  localparam int unsigned COORD_W         = 32;
  localparam int unsigned ITER_W          = 3;
  localparam logic [ITER_W-1:0] ITER_RESET = 3'd1;

  // which child of a frame is taken next
  localparam logic [1:0] KIND_Q = 2'd0;
  localparam logic [1:0] KIND_R = 2'd1;
  localparam logic [1:0] KIND_L = 2'd2;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic                      last;
  } ccs_point_t;

  typedef struct packed {
    logic              clear;
    logic [ITER_W-1:0] iterations;
  } ccs_ctrl_t;

  // floor((3a + b) / 4), exact in 34 bits, always fits back in 32
  function automatic logic signed [COORD_W-1:0] cut(input logic signed [COORD_W-1:0] a,
                                                    input logic signed [COORD_W-1:0] b);
    logic signed [COORD_W+1:0] ae;
    logic signed [COORD_W+1:0] be;
    logic signed [COORD_W+1:0] s;
    ae = {{2{a[COORD_W-1]}}, a};
    be = {{2{b[COORD_W-1]}}, b};
    s  = (ae <<< 1) + ae + be;
    return s[COORD_W+1:2];
  endfunction

endpackage

`default_nettype wire

// File: hdl/ccs_if.sv
// ----------------------------------------------------------------------------
// ccs_if
// Channel interfaces: input points, result points and the config write.
// ----------------------------------------------------------------------------
`default_nettype none

interface ccs_point_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [ccs_pkg::COORD_W-1:0]   point_x;
  logic signed [ccs_pkg::COORD_W-1:0]   point_y;
  logic signed [ccs_pkg::COORD_W-1:0]   point_z;
  logic                                 last_point;
  modport source (output valid, point_x, point_y, point_z, last_point, input ready);
  modport sink   (input valid, point_x, point_y, point_z, last_point, output ready);
endinterface

interface ccs_result_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [ccs_pkg::COORD_W-1:0]   out_x;
  logic signed [ccs_pkg::COORD_W-1:0]   out_y;
  logic signed [ccs_pkg::COORD_W-1:0]   out_z;
  logic                                 end_of_run;
  logic                                 end_of_curve;
  modport source (output valid, out_x, out_y, out_z, end_of_run, end_of_curve, input ready);
  modport sink   (input valid, out_x, out_y, out_z, end_of_run, end_of_curve, output ready);
endinterface

interface ccs_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [ccs_pkg::ITER_W-1:0]        iterations;
  modport source (output valid, iterations, input ready);
  modport sink   (input valid, iterations, output ready);
endinterface

`default_nettype wire

// File: hdl/ccs_queue.sv
// ----------------------------------------------------------------------------
// ccs_queue
// Front part: takes input points and holds them in a short queue for the engine.
// ----------------------------------------------------------------------------
`default_nettype none

module ccs_queue #(
  parameter int unsigned DEPTH = ccs_pkg::QUEUE_DEPTH_DEF
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  ccs_point_if.sink           point_i,
  output logic                q_valid_o,
  output ccs_pkg::ccs_point_t q_data_o,
  input  wire                 q_pop_i
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  ccs_pkg::ccs_point_t mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic          push, pop;

  assign point_i.ready = (count_q < CW'(DEPTH));
  assign push          = point_i.valid && point_i.ready;
  assign q_valid_o     = (count_q != '0);
  assign pop           = q_pop_i && q_valid_o;
  assign q_data_o      = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= '{x: point_i.point_x, y: point_i.point_y,
                           z: point_i.point_z, last: point_i.last_point};
    end
  end

endmodule

`default_nettype wire

// File: hdl/ccs_engine.sv
// ----------------------------------------------------------------------------
// ccs_engine
// Back part: walks the pass cascade depth first, one point per cycle unless a
// result waits on the full result register it drives, with a frame of pending children per pass.
// ----------------------------------------------------------------------------
`default_nettype none

module ccs_engine #(
  parameter int unsigned ITER_MAX = ccs_pkg::ITER_MAX_DEF
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire ccs_pkg::ccs_ctrl_t  ctrl_i,
  input  wire                      q_valid_i,
  input  wire ccs_pkg::ccs_point_t q_data_i,
  output logic                     q_pop_o,
  ccs_result_if.source             result_o
);

  localparam int unsigned LW = (ITER_MAX > 1) ? $clog2(ITER_MAX) : 1;
  localparam int unsigned SW = ccs_pkg::ITER_W;
  localparam int unsigned CW = ccs_pkg::COORD_W;

  // per-pass state
  logic signed [CW-1:0] prev_y_q [ITER_MAX];
  logic signed [CW-1:0] prev_z_q [ITER_MAX];
  logic [ITER_MAX-1:0]  has_prev_q;

  // per-pass frames: a = held point, b = incoming point
  logic signed [CW-1:0] fa_y_q [ITER_MAX];
  logic signed [CW-1:0] fa_z_q [ITER_MAX];
  logic signed [CW-1:0] fb_x_q [ITER_MAX];
  logic signed [CW-1:0] fb_y_q [ITER_MAX];
  logic signed [CW-1:0] fb_z_q [ITER_MAX];
  logic [ITER_MAX-1:0]  pend_q_q, pend_r_q, pend_l_q;

  // frame view with the current pass's new frame folded in
  logic signed [CW-1:0] va_y [ITER_MAX];
  logic signed [CW-1:0] va_z [ITER_MAX];
  logic signed [CW-1:0] vb_x [ITER_MAX];
  logic signed [CW-1:0] vb_y [ITER_MAX];
  logic signed [CW-1:0] vb_z [ITER_MAX];
  logic [ITER_MAX-1:0]  v_pq, v_pr, v_pl;

  logic                 busy_q;
  ccs_pkg::ccs_point_t  cur_q, child;
  logic [SW-1:0]        cur_s_q;

  logic                 out_v_q;
  ccs_pkg::ccs_point_t  out_pt_q;
  logic                 out_eor_q;

  logic [SW-1:0]        passes;
  logic                 leaf, internal, out_free, advance, emit, pending_any;
  logic [LW-1:0]        sel;
  logic [1:0]           kind;
  logic signed [CW-1:0] op_ay, op_by, op_az, op_bz;

  assign passes   = (ctrl_i.iterations > SW'(ITER_MAX)) ? SW'(ITER_MAX) : ctrl_i.iterations;
  assign leaf     = (cur_s_q >= passes);
  assign internal = busy_q && !leaf;
  assign out_free = !out_v_q || result_o.ready;
  assign advance  = busy_q && (!leaf || out_free);
  assign emit     = busy_q && leaf && out_free;

  always_comb begin
    for (int i = 0; i < ITER_MAX; i++) begin
      va_y[i] = fa_y_q[i];
      va_z[i] = fa_z_q[i];
      vb_x[i] = fb_x_q[i];
      vb_y[i] = fb_y_q[i];
      vb_z[i] = fb_z_q[i];
      v_pq[i] = pend_q_q[i];
      v_pr[i] = pend_r_q[i];
      v_pl[i] = pend_l_q[i];
      if (internal && (cur_s_q == SW'(i))) begin
        va_y[i] = prev_y_q[i];
        va_z[i] = prev_z_q[i];
        vb_x[i] = cur_q.x;
        vb_y[i] = cur_q.y;
        vb_z[i] = cur_q.z;
        v_pq[i] = has_prev_q[i];
        v_pr[i] = has_prev_q[i];
        v_pl[i] = cur_q.last;
      end
    end
  end

  // deepest pass with work left is served first
  always_comb begin
    sel = '0;
    for (int i = 0; i < ITER_MAX; i++) begin
      if (v_pq[i] || v_pr[i] || v_pl[i]) begin
        sel = LW'(i);
      end
    end
  end

  assign pending_any = |(v_pq | v_pr | v_pl);

  always_comb begin
    if (v_pq[sel]) begin
      kind = ccs_pkg::KIND_Q;
    end else if (v_pr[sel]) begin
      kind = ccs_pkg::KIND_R;
    end else begin
      kind = ccs_pkg::KIND_L;
    end
  end

  // one cut per coordinate, operands swapped for the three-quarter point
  always_comb begin
    if (kind == ccs_pkg::KIND_Q) begin
      op_ay = va_y[sel];
      op_by = vb_y[sel];
      op_az = va_z[sel];
      op_bz = vb_z[sel];
    end else begin
      op_ay = vb_y[sel];
      op_by = va_y[sel];
      op_az = vb_z[sel];
      op_bz = va_z[sel];
    end
    if (kind == ccs_pkg::KIND_L) begin
      child = '{x: vb_x[sel], y: vb_y[sel], z: vb_z[sel], last: 1'b1};
    end else begin
      child = '{x: '0, y: ccs_pkg::cut(op_ay, op_by), z: ccs_pkg::cut(op_az, op_bz),
                last: 1'b0};
    end
  end

  assign q_pop_o = q_valid_i && (!busy_q || (advance && !pending_any));

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      cur_s_q    <= '0;
      has_prev_q <= '0;
      pend_q_q   <= '0;
      pend_r_q   <= '0;
      pend_l_q   <= '0;
      out_v_q    <= 1'b0;
    end else begin
      if (emit) begin
        out_v_q <= 1'b1;
      end else if (result_o.ready) begin
        out_v_q <= 1'b0;
      end
      if (ctrl_i.clear) begin
        has_prev_q <= '0;
        pend_q_q   <= '0;
        pend_r_q   <= '0;
        pend_l_q   <= '0;
      end else if (!busy_q) begin
        if (q_valid_i) begin
          busy_q  <= 1'b1;
          cur_s_q <= '0;
        end
      end else if (advance) begin
        if (internal) begin
          for (int i = 0; i < ITER_MAX; i++) begin
            if (cur_s_q == SW'(i)) begin
              has_prev_q[i] <= !cur_q.last;
            end
          end
        end
        for (int i = 0; i < ITER_MAX; i++) begin
          pend_q_q[i] <= v_pq[i] && !(sel == LW'(i) && kind == ccs_pkg::KIND_Q);
          pend_r_q[i] <= v_pr[i] && !(sel == LW'(i) && kind == ccs_pkg::KIND_R);
          pend_l_q[i] <= v_pl[i] && !(sel == LW'(i) && kind == ccs_pkg::KIND_L);
        end
        if (pending_any) begin
          cur_s_q <= SW'(sel) + SW'(1);
        end else if (q_valid_i) begin
          cur_s_q <= '0;
        end else begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cur_q <= q_data_i;
    end else if (advance && pending_any) begin
      cur_q <= child;
    end
    if (internal && advance) begin
      for (int i = 0; i < ITER_MAX; i++) begin
        if (cur_s_q == SW'(i)) begin
          fa_y_q[i] <= va_y[i];
          fa_z_q[i] <= va_z[i];
          fb_x_q[i] <= vb_x[i];
          fb_y_q[i] <= vb_y[i];
          fb_z_q[i] <= vb_z[i];
          if (!cur_q.last) begin
            prev_y_q[i] <= cur_q.y;
            prev_z_q[i] <= cur_q.z;
          end
        end
      end
    end
    if (emit) begin
      out_pt_q  <= cur_q;
      out_eor_q <= !pending_any;
    end
  end

  assign result_o.valid        = out_v_q;
  assign result_o.out_x        = out_pt_q.x;
  assign result_o.out_y        = out_pt_q.y;
  assign result_o.out_z        = out_pt_q.z;
  assign result_o.end_of_run   = out_eor_q;
  assign result_o.end_of_curve = out_pt_q.last;

endmodule

`default_nettype wire

// File: hdl/chaikin_curve_smoothing.sv
// ----------------------------------------------------------------------------
// chaikin_curve_smoothing
// Open-curve Chaikin corner cutting in the y-z plane over a cascade of passes.
// ----------------------------------------------------------------------------
// The engine visits one point of the pass cascade per cycle unless a result
// waits on a full result register: an interior point under N passes visits
// 2^(N+1)-1 points and yields 2^N results (32 results at five passes), set by
// the depth-first walk of the engine.
// Reset is asynchronous: queue, engine and result register empty, iterations
// back to 1, no held points; no clearing pass.
`default_nettype none

module chaikin_curve_smoothing #(
  parameter int unsigned ITER_MAX    = ccs_pkg::ITER_MAX_DEF,
  parameter int unsigned QUEUE_DEPTH = ccs_pkg::QUEUE_DEPTH_DEF
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  ccs_cfg_if.sink      cfg_i,
  ccs_point_if.sink    point_i,
  ccs_result_if.source result_o
);

  logic [ccs_pkg::ITER_W-1:0] iter_q;
  ccs_pkg::ccs_ctrl_t         ctrl;
  logic                       q_valid, q_pop;
  ccs_pkg::ccs_point_t        q_data;

  assign cfg_i.ready     = 1'b1;
  assign ctrl.clear      = cfg_i.valid && cfg_i.ready;
  assign ctrl.iterations = iter_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iter_q <= ccs_pkg::ITER_RESET;
    end else if (ctrl.clear) begin
      iter_q <= cfg_i.iterations;
    end
  end

  ccs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .point_i   (point_i),
    .q_valid_o (q_valid),
    .q_data_o  (q_data),
    .q_pop_i   (q_pop)
  );

  ccs_engine #(
    .ITER_MAX (ITER_MAX)
  ) u_engine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .q_valid_i (q_valid),
    .q_data_i  (q_data),
    .q_pop_o   (q_pop),
    .result_o  (result_o)
  );

  // the curve's last word also closes the run of its input point
  a_eoc_closes_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && result_o.end_of_curve |-> result_o.end_of_run)
    else $error("end_of_curve without end_of_run");

  // with passes active, only the final point keeps its x
  a_cut_x_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && !result_o.end_of_curve && (iter_q != '0) && !ctrl.clear
    && !$past(ctrl.clear) |-> (result_o.out_x == '0))
    else $error("cut point with non-zero x");

endmodule

`default_nettype wire
